// ----- sv/pfa_pkg.sv -----
// Shared types and constants of the partition fit allocator.
package pfa_pkg;

	// Fixed field widths
	localparam int AMT_W      = 16;
	localparam int OUT_IDX_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	typedef logic [AMT_W-1:0]      amount_t;
	typedef logic [OUT_IDX_W-1:0]  part_idx_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	// Fit policies
	localparam logic POLICY_FIRST = 1'b0;
	localparam logic POLICY_WORST = 1'b1;

	// Register indexes
	localparam cfg_idx_t REG_FIT_POLICY      = 1'b0;
	localparam cfg_idx_t REG_PARTITION_COUNT = 1'b1;

	// Register reset values
	localparam logic      FIT_POLICY_RESET = POLICY_FIRST;
	localparam cfg_data_t COUNT_RESET      = 5'd16;

endpackage

// ----- sv/pfa_req_if.sv -----
// Request channel of the partition fit allocator.
interface pfa_req_if;
	logic               valid;
	logic               ready;
	logic               mode;
	pfa_pkg::part_idx_t load_index;
	pfa_pkg::amount_t   amount;

	modport source (output valid, output mode, output load_index, output amount, input ready);
	modport sink   (input valid, input mode, input load_index, input amount, output ready);
endinterface

// ----- sv/pfa_rsp_if.sv -----
// Response channel of the partition fit allocator.
interface pfa_rsp_if;
	logic               valid;
	logic               ready;
	logic               granted;
	pfa_pkg::part_idx_t chosen_index;
	pfa_pkg::amount_t   remaining;

	modport source (output valid, output granted, output chosen_index, output remaining,
		input ready);
	modport sink   (input valid, input granted, input chosen_index, input remaining,
		output ready);
endinterface

// ----- sv/partition_fit_allocator_top.sv -----
// Top level of the partition fit allocator: free-size table, scan sequencer and result register.
//
//   Channel  Dir  Handshake        Payload
//   req      in   valid / ready    mode, load_index, amount
//   rsp      out  valid / ready    granted, chosen_index, remaining
//   cfg      in   cfg_we only      cfg_index, cfg_wdata
//
// A load beat, and a request with no partitions to search, goes from acceptance straight to
// ST_FINISH and on into the output register once it is free; req is ready again after that.
// An allocate beat runs ST_SCAN over the first L table entries, where L is the clamped
// partition count, then ST_LAST, ST_UPDATE and ST_FINISH; one compare unit looks at one
// table entry per cycle behind the single read port of the free-size RAM, so L sets its length.
// Reset clears the valid bits at once, so every partition reads as zero free size and
// no clearing pass is needed. A stalled rsp holds the finished result; one more item
// may be accepted meanwhile and waits in its final state until the output register frees.
module partition_fit_allocator_top #(
	parameter int NUM_PARTITIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	pfa_req_if.sink             req,
	pfa_rsp_if.source           rsp,
	input  logic                cfg_we,
	input  pfa_pkg::cfg_idx_t   cfg_index,
	input  pfa_pkg::cfg_data_t  cfg_wdata
);

	localparam int IDX_W = $clog2(NUM_PARTITIONS);
	localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_LAST   = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]             state_q;

	// Configuration registers
	logic                   policy_q;
	pfa_pkg::cfg_data_t     count_q;

	// Item context
	pfa_pkg::amount_t       amt_q;
	logic [CNT_W-1:0]       limit_q;
	logic [IDX_W-1:0]       scan_q;

	// Search result so far
	logic                   found_q;
	logic [IDX_W-1:0]       pick_q;
	pfa_pkg::amount_t       best_q;

	// Staged result, moved to the output register in ST_FINISH
	logic                   granted_q;
	pfa_pkg::part_idx_t     chosen_q;
	pfa_pkg::amount_t       remaining_q;

	// Output register
	logic                   rsp_vld_q;
	logic                   rsp_granted_q;
	pfa_pkg::part_idx_t     rsp_chosen_q;
	pfa_pkg::amount_t       rsp_remaining_q;

	// Table: RAM holds the sizes, valid bits tell written entries from reset zeros
	logic [NUM_PARTITIONS-1:0] valid_q;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	pfa_pkg::amount_t       ram_wdata;
	logic                   ram_re;
	pfa_pkg::amount_t       ram_rdata;

	// Compare stage, registered from the read address alongside the RAM read data
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;

	logic                   req_fire;
	logic                   load_in_range;
	logic [CNT_W-1:0]       limit_in;
	pfa_pkg::amount_t       cmp_data;
	logic                   cmp_take;
	logic                   scan_done;
	pfa_pkg::amount_t       sub_result;
	logic                   out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// Only indexes inside the table are written by a load.
	assign load_in_range = (32'(req.load_index) < NUM_PARTITIONS);

	// Counts above the table size search the whole table.
	assign limit_in = (32'(count_q) > NUM_PARTITIONS) ? CNT_W'(NUM_PARTITIONS)
		: CNT_W'(count_q);

	// An entry never written reads as zero free size.
	assign cmp_data = valid_q[cmp_idx_s1] ? ram_rdata : '0;

	// First fit keeps the first hit; worst fit moves only on a strictly larger size,
	// which keeps the lowest index on a tie.
	assign cmp_take = cmp_vld_s1 && (cmp_data >= amt_q) &&
		(!found_q || ((policy_q == pfa_pkg::POLICY_WORST) && (cmp_data > best_q)));

	assign scan_done  = ((CNT_W'(scan_q) + CNT_W'(1)) == limit_q);
	assign sub_result = best_q - amt_q;
	assign out_free   = !rsp_vld_q || rsp.ready;

	// Single write port: loads write at acceptance, grants write in ST_UPDATE.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(req.load_index);
		ram_wdata = req.amount;
		if (req_fire && (req.mode == pfa_pkg::MODE_LOAD) && load_in_range) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_UPDATE) && found_q) begin
			ram_we    = 1'b1;
			ram_waddr = pick_q;
			ram_wdata = sub_result;
		end
	end

	assign ram_re = (state_q == ST_SCAN);

	pfa_ram #(
		.WIDTH (pfa_pkg::AMT_W),
		.DEPTH (NUM_PARTITIONS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfa_pkg::FIT_POLICY_RESET;
			count_q  <= pfa_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfa_pkg::REG_FIT_POLICY: begin
					policy_q <= cfg_wdata[0];
				end
				pfa_pkg::REG_PARTITION_COUNT: begin
					count_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Valid bits of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Sequencer and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= ram_re;
			if (cmp_take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						found_q <= 1'b0;
						if (req.mode == pfa_pkg::MODE_LOAD) begin
							state_q <= ST_FINISH;
						end else if (limit_in == '0) begin
							// Nothing to search: the request misses.
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the search
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
		if (cmp_take) begin
			pick_q <= cmp_idx_s1;
			best_q <= cmp_data;
		end
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					amt_q   <= req.amount;
					limit_q <= limit_in;
					scan_q  <= '0;
					// Loads and empty searches stage their result right away.
					granted_q   <= 1'b0;
					chosen_q    <= (req.mode == pfa_pkg::MODE_LOAD) ? req.load_index : '0;
					remaining_q <= ((req.mode == pfa_pkg::MODE_LOAD) && load_in_range)
						? req.amount : '0;
				end
			end
			ST_SCAN: begin
				if (!scan_done) begin
					scan_q <= scan_q + IDX_W'(1);
				end
			end
			ST_UPDATE: begin
				granted_q   <= found_q;
				chosen_q    <= found_q ? pfa_pkg::OUT_IDX_W'(pick_q) : '0;
				remaining_q <= found_q ? sub_result : '0;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			rsp_granted_q   <= granted_q;
			rsp_chosen_q    <= chosen_q;
			rsp_remaining_q <= remaining_q;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.granted      = rsp_granted_q;
	assign rsp.chosen_index = rsp_chosen_q;
	assign rsp.remaining    = rsp_remaining_q;

`ifndef SYNTHESIS
	// One item at a time: right after a beat is taken the block is busy and req is not ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request accepted on two consecutive cycles");

	// The table is never written while it is being scanned.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) || (state_q == ST_LAST) |-> !ram_we)
		else $error("table written during a scan");

	// A granted partition lies inside the table.
	a_grant_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.granted |-> (32'(rsp.chosen_index) < NUM_PARTITIONS))
		else $error("granted partition outside the table");
`endif

endmodule

// ----- sv/pfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- bench/allocation_checker.sv -----
`timescale 1ns / 1ps
// Allocation checker: predicts each response beat from request and register beats and compares.
module allocation_checker #(
	parameter int NUM_PARTITIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	pfa_req_if                 req,
	pfa_rsp_if                 rsp,
	input  logic               cfg_we,
	input  pfa_pkg::cfg_idx_t  cfg_index,
	input  pfa_pkg::cfg_data_t cfg_wdata,
	output int                 mismatch_count,
	output int                 awaited_count
);
	import pfa_pkg::*;

	typedef struct packed {
		logic      granted;
		part_idx_t chosen_index;
		amount_t   remaining;
	} alloc_result_t;

	amount_t       free_size [NUM_PARTITIONS];
	logic          policy;
	cfg_data_t     part_count;
	alloc_result_t awaited_results [$];
	int            errors = 0;

	// Applies one request beat to the free-size table and returns the response it should give.
	function automatic alloc_result_t serve_request(logic mode, part_idx_t idx, amount_t amt);
		alloc_result_t r;
		int            span;
		int            best;
		logic          hit;
		r = '0;
		best = 0;
		hit = 1'b0;
		if (mode == MODE_LOAD) begin
			r.chosen_index = idx;
			if (idx < NUM_PARTITIONS) begin
				free_size[idx] = amt;
				r.remaining = amt;
			end
			return r;
		end
		span = (part_count > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(part_count);
		for (int j = 0; j < span; j++) begin
			// First fit stops looking at the first hit; worst fit only moves on a strictly
			// larger size, so a tie keeps the lowest index.
			if (!(hit && policy == POLICY_FIRST) && free_size[j] >= amt) begin
				if (!hit || free_size[j] > free_size[best])
					best = j;
				hit = 1'b1;
			end
		end
		if (hit) begin
			free_size[best] = free_size[best] - amt;
			r.granted = 1'b1;
			r.chosen_index = part_idx_t'(best);
			r.remaining = free_size[best];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		alloc_result_t got;
		if (!arst_n) begin
			foreach (free_size[i])
				free_size[i] = '0;
			policy = FIT_POLICY_RESET;
			part_count = COUNT_RESET;
			awaited_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FIT_POLICY)
					policy = cfg_wdata[0];
				else if (cfg_index == REG_PARTITION_COUNT)
					part_count = cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				got.granted = rsp.granted;
				got.chosen_index = rsp.chosen_index;
				got.remaining = rsp.remaining;
				if (awaited_results.size() == 0) begin
					errors++;
					$error("unexpected response beat: granted %0d, chosen_index %0d, remaining %0d",
						got.granted, got.chosen_index, got.remaining);
				end else begin
					want = awaited_results.pop_front();
					if (got.granted !== want.granted) begin
						errors++;
						$error("granted: expected %0d, got %0d", want.granted, got.granted);
					end
					if (got.chosen_index !== want.chosen_index) begin
						errors++;
						$error("chosen_index: expected %0d, got %0d", want.chosen_index,
							got.chosen_index);
					end
					if (got.remaining !== want.remaining) begin
						errors++;
						$error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
					end
				end
			end
			if (req.valid && req.ready)
				awaited_results.push_back(serve_request(req.mode, req.load_index, req.amount));
		end
		mismatch_count <= errors;
		awaited_count <= awaited_results.size();
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: drives request, register and back-pressure stimulus and reports the verdict.
module tb_top;
	import pfa_pkg::*;

	localparam int NUM_PARTS     = 16;
	// Long enough to cover any allocate beat still in flight.
	localparam int SETTLE_CYCLES = 24;
	// Long enough for the block to fill both its output register and its waiting slot.
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 500000;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_wdata;
	int        mismatches;
	int        awaited;
	int        cycles = 0;

	// Shared with the response sink: no idling on either side, and a one-time long hold-off.
	logic smooth;
	logic hold_armed;

	pfa_req_if req_ch ();
	pfa_rsp_if rsp_ch ();

	partition_fit_allocator_top #(
		.NUM_PARTITIONS(NUM_PARTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	allocation_checker #(
		.NUM_PARTITIONS(NUM_PARTS)
	) u_allocation_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatches),
		.awaited_count  (awaited)
	);

	// 2 ns clock, low first so the first rising edge comes at 1 ns.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Response sink. Ready drops about 18 percent of the time unless the current phase
	// asks for a smooth stretch. Once armed, it holds ready low for a long stretch, counted
	// here, while the sender keeps offering beats, so the block backs up and stalls req.
	initial begin : response_sink
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ch.ready <= smooth || ($urandom_range(99) >= 18);
		end
	end

	// Offers one request beat and returns at the edge where it is accepted. Valid stays high
	// into the next beat unless a random gap is drawn, so back-to-back beats are covered too.
	task automatic send_item(input logic mode, input part_idx_t idx, input amount_t amt);
		if (!smooth && $urandom_range(99) < 18) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.load_index <= idx;
		req_ch.amount <= amt;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drops valid, waits for every predicted response to arrive, then lets the block settle.
	// The awaited count is registered, so the task waits on a clock edge before reading it.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers are only touched while the block is idle: drain first, then write both.
	task automatic reconfigure(input logic policy, input cfg_data_t count);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_FIT_POLICY;
		cfg_wdata <= cfg_data_t'(policy);
		@(posedge clk);
		cfg_index <= REG_PARTITION_COUNT;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random phase under a fixed setting. Loads favor small and repeated sizes so that
	// worst-fit ties and exact fits come up; requests favor small sizes so grants are common,
	// with full-range and zero requests mixed in.
	task automatic run_random_phase(input logic policy, input cfg_data_t count, input int items,
		input logic no_gaps, input logic with_hold);
		logic      mode;
		part_idx_t idx;
		amount_t   amt;
		reconfigure(policy, count);
		smooth <= no_gaps;
		hold_armed <= with_hold;
		for (int n = 0; n < items; n++) begin
			idx = part_idx_t'($urandom_range(15));
			if ($urandom_range(99) < 35) begin
				mode = MODE_LOAD;
				case ($urandom_range(3))
					0: amt = amount_t'($urandom_range(255));
					1: amt = amount_t'($urandom_range(4) * 64);
					2: amt = amount_t'($urandom);
					default: amt = 16'hFFFF - amount_t'($urandom_range(3));
				endcase
			end else begin
				mode = MODE_ALLOC;
				case ($urandom_range(4))
					0, 1: amt = amount_t'($urandom_range(63));
					2: amt = amount_t'($urandom_range(4095));
					3: amt = amount_t'($urandom);
					default: amt = '0;
				endcase
			end
			send_item(mode, idx, amt);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FIT_POLICY;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_LOAD;
		req_ch.load_index = '0;
		req_ch.amount = '0;
		smooth = 1'b0;
		hold_armed = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting, first fit over all sixteen. On the empty table a zero request is
		// granted at partition zero and any nonzero request misses.
		send_item(MODE_ALLOC, 4'd9, 16'h0000);
		send_item(MODE_ALLOC, 4'd0, 16'h0001);
		send_item(MODE_LOAD, 4'd0, 16'hFFFF);
		send_item(MODE_LOAD, 4'd15, 16'h8000);
		send_item(MODE_LOAD, 4'd5, 16'd100);
		send_item(MODE_LOAD, 4'd10, 16'h7FFF);
		// A full-size request empties partition zero; the next ones skip it.
		send_item(MODE_ALLOC, 4'd0, 16'hFFFF);
		send_item(MODE_ALLOC, 4'd0, 16'd50);
		send_item(MODE_ALLOC, 4'd0, 16'h8000);

		// Worst fit: the largest size wins, and on a tie the lowest index.
		reconfigure(POLICY_WORST, 5'd16);
		send_item(MODE_LOAD, 4'd3, 16'd1000);
		send_item(MODE_LOAD, 4'd7, 16'd1000);
		send_item(MODE_ALLOC, 4'd0, 16'd10);
		send_item(MODE_LOAD, 4'd10, 16'd1000);
		send_item(MODE_ALLOC, 4'd0, 16'd1);
		send_item(MODE_ALLOC, 4'd0, 16'd0);

		// With no partitions in the search every request misses, but loads still land.
		reconfigure(POLICY_FIRST, 5'd0);
		send_item(MODE_ALLOC, 4'd0, 16'd0);
		send_item(MODE_LOAD, 4'd2, 16'd5);

		// A single partition: only partition zero, which is empty, can be picked.
		reconfigure(POLICY_WORST, 5'd1);
		send_item(MODE_ALLOC, 4'd0, 16'd0);
		send_item(MODE_ALLOC, 4'd0, 16'd1);

		// A count above the table size searches the whole table, up to partition 15.
		reconfigure(POLICY_FIRST, 5'd31);
		send_item(MODE_LOAD, 4'd15, 16'hAAAA);
		send_item(MODE_ALLOC, 4'd0, 16'h5555);
		send_item(MODE_ALLOC, 4'd0, 16'h5556);

		// Random phases. The first carries the long receiver hold-off, the second runs with
		// no idling on either side, then the count extremes, then random settings.
		run_random_phase(POLICY_WORST, 5'd16, 250, 1'b0, 1'b1);
		run_random_phase(POLICY_FIRST, 5'd16, 250, 1'b1, 1'b0);
		run_random_phase(POLICY_FIRST, 5'd1, 150, 1'b0, 1'b0);
		run_random_phase(POLICY_WORST, 5'd31, 250, 1'b0, 1'b0);
		run_random_phase(POLICY_WORST, 5'd0, 50, 1'b0, 1'b0);
		for (int p = 0; p < 3; p++)
			run_random_phase(logic'($urandom_range(1)), cfg_data_t'($urandom_range(2, 17)),
				200, 1'b0, 1'b0);

		wait_drained();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pfa_pkg.sv
sv/pfa_req_if.sv
sv/pfa_rsp_if.sv
sv/pfa_ram.sv
sv/partition_fit_allocator_top.sv
bench/allocation_checker.sv
bench/tb_top.sv
